// ===== sv/merge_two_sorted_lists_macros.svh =====
// Assertion macros used by the datapath RTL file of the merge block.
`ifndef MERGE_TWO_SORTED_LISTS_MACROS_SVH
`define MERGE_TWO_SORTED_LISTS_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define MTSL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge block: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define MTSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge block: next-cycle check failed");

`endif

// ===== sv/mtsl_pkg.sv =====
package mtsl_pkg;

  // Default number of entries in each list store
  localparam int unsigned LIST_DEPTH_DEF = 16;

  // Input command codes
  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_MERGE    = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_a;      // append value to store A
    logic wr_b;      // append value to store B
    logic ovf;       // push an overflow result
    logic rd_start;  // rewind read positions
    logic emit;      // push the smaller head and advance
    logic clr;       // empty both stores
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full_a;
    logic full_b;
    logic empty;     // both stores hold nothing
    logic last;      // next emitted element ends the run
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

// ===== sv/mtsl_ctrl.sv =====
module mtsl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_cmd_i,
  input  mtsl_pkg::status_t status_i,
  output mtsl_pkg::cmd_t   cmd_o
);
  import mtsl_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Take commands only when idle and the output register can hold a result
  assign in_ready_o = (state_q == StIdle) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_APPEND_A: begin
              if (status_i.full_a) cmd_o.ovf = 1'b1;
              else cmd_o.wr_a = 1'b1;
            end
            CMD_APPEND_B: begin
              if (status_i.full_b) cmd_o.ovf = 1'b1;
              else cmd_o.wr_b = 1'b1;
            end
            CMD_MERGE: begin
              cmd_o.rd_start = 1'b1;
              state_d        = StRead;
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        if (status_i.empty) begin
          cmd_o.clr = 1'b1;
          state_d   = StIdle;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            cmd_o.clr = 1'b1;
            state_d   = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/mtsl_dpath.sv =====
`include "merge_two_sorted_lists_macros.svh"
module mtsl_dpath #(
  parameter int unsigned LIST_DEPTH = mtsl_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] in_value_i,
  input  mtsl_pkg::cmd_t     cmd_i,
  output mtsl_pkg::status_t  status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_value_o,
  output logic               out_last_o,
  output logic               out_ovf_o
);
  import mtsl_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned SW = CW + 1;

  logic signed [31:0] mem_a [LIST_DEPTH];
  logic signed [31:0] mem_b [LIST_DEPTH];

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] pos_a_q, pos_a_d, pos_b_q, pos_b_d;
  logic signed [31:0] head_a_q, head_b_q;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic               out_last_q, out_last_d;
  logic               out_ovf_q, out_ovf_d;

  logic          avail_a, avail_b, take_a;
  logic [SW-1:0] total, done;

  // Head selection: A wins on equal values
  assign avail_a = pos_a_q < cnt_a_q;
  assign avail_b = pos_b_q < cnt_b_q;
  assign take_a  = avail_a && (!avail_b || (head_a_q <= head_b_q));
  assign total   = SW'(cnt_a_q) + SW'(cnt_b_q);
  assign done    = SW'(pos_a_q) + SW'(pos_b_q) + SW'(1);

  assign status_o.full_a   = cnt_a_q == CW'(LIST_DEPTH);
  assign status_o.full_b   = cnt_b_q == CW'(LIST_DEPTH);
  assign status_o.empty    = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign status_o.last     = done == total;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Counters and read positions
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    pos_a_d = pos_a_q;
    pos_b_d = pos_b_q;
    if (cmd_i.wr_a) cnt_a_d = cnt_a_q + CW'(1);
    if (cmd_i.wr_b) cnt_b_d = cnt_b_q + CW'(1);
    if (cmd_i.emit) begin
      if (take_a) pos_a_d = pos_a_q + CW'(1);
      else pos_b_d = pos_b_q + CW'(1);
    end
    if (cmd_i.rd_start || cmd_i.clr) begin
      pos_a_d = '0;
      pos_b_d = '0;
    end
    if (cmd_i.clr) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
    end
  end

  // Output register: load a result or drain the held one
  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_value_d = take_a ? head_a_q : head_b_q;
      out_last_d  = status_o.last;
      out_ovf_d   = 1'b0;
    end else if (cmd_i.ovf) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      out_last_d  = 1'b0;
      out_ovf_d   = 1'b1;
    end
  end

  // Stores: write at the fill count, read ahead at the next position
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) mem_a[cnt_a_q[AW-1:0]] <= in_value_i;
    if (cmd_i.wr_b) mem_b[cnt_b_q[AW-1:0]] <= in_value_i;
    head_a_q <= mem_a[pos_a_d[AW-1:0]];
    head_b_q <= mem_b[pos_b_d[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      pos_a_q     <= '0;
      pos_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      pos_a_q     <= pos_a_d;
      pos_b_q     <= pos_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  `MTSL_ASSERT_SAME(emit_has_elem_a, cmd_i.emit, avail_a || avail_b)
  `MTSL_ASSERT_SAME(pos_within_cnt_a, 1'b1, (pos_a_q <= cnt_a_q) && (pos_b_q <= cnt_b_q))
  `MTSL_ASSERT_SAME(cnt_within_depth_a, 1'b1,
                    (cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
  `MTSL_ASSERT_NEXT(clr_empties_a, cmd_i.clr, (cnt_a_q == '0) && (cnt_b_q == '0))

endmodule

// ===== sv/merge_two_sorted_lists.sv =====
// Load (cmd 0 or 1): one transaction per cycle while idle with the output register free,
//   no result; a load into a full store returns one overflow result in the next cycle.
// Merge of N stored elements: a read state first loads both store heads through the
//   registered store read port, then one element per cycle while the output register is free.
// Reset clears the counts, read positions and output valid; the stores are left as they
//   are, since entries are only read below the fill count, and no clearing pass is run.
module merge_two_sorted_lists #(
  parameter int unsigned LIST_DEPTH = mtsl_pkg::LIST_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] merged_value
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] overflow
);
  import mtsl_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic signed [31:0] out_value;

  // Sequence loads and merges
  mtsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the lists and drive the output register
  mtsl_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  ($signed(s_axis_tdata_i)),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o),
    .out_ovf_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = $unsigned(out_value);

endmodule
